/* src/gwdf_pkg.sv */
package gwdf_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int DIST_BITS_DEF  = 16;

    localparam int MIN_DIM       = 3;
    localparam int STEP_STRAIGHT = 10;
    localparam int STEP_DIAGONAL = 14;
    localparam int NDIRS         = 8;
    localparam int COORD_W       = 10;

    localparam int DIR_DX [NDIRS] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    localparam int DIR_DY [NDIRS] = '{0, 1, 1, 1, 0, -1, -1, -1};

    localparam logic [2:0] CMD_LOAD    = 3'd0;
    localparam logic [2:0] CMD_REBUILD = 3'd1;
    localparam logic [2:0] CMD_SET     = 3'd2;
    localparam logic [2:0] CMD_TRIAL   = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;

    localparam logic [2:0] STAT_DONE     = 3'd0;
    localparam logic [2:0] STAT_OUTSIDE  = 3'd1;
    localparam logic [2:0] STAT_PROTECT  = 3'd2;
    localparam logic [2:0] STAT_NOCHANGE = 3'd3;
    localparam logic [2:0] STAT_UNREACH  = 3'd4;
    localparam logic [2:0] STAT_NODIST   = 3'd5;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH0,
        ST_FETCH1,
        ST_FETCH2,
        ST_FETCH3,
        ST_OPER,
        ST_SW_PRE,
        ST_SW_LOAD,
        ST_SW_RD,
        ST_SW_WR,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_ROUND,
        PH_RESTORE
    } phase_t;

endpackage

/* src/gwdf_ram.sv */
module gwdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/gwdf_cell.sv */
module gwdf_cell #(
    parameter int DIST_BITS = 16
) (
    input  logic [8:0]             nb_blk,
    input  logic [8:0]             nb_fr,
    input  logic [9*DIST_BITS-1:0] nb_dist,
    input  logic                   self_vld,
    input  logic                   in_map,
    output logic                   new_vld,
    output logic                   new_fr,
    output logic [DIST_BITS-1:0]   new_dist,
    output logic                   grew
);

    import gwdf_pkg::*;

    localparam logic [DIST_BITS:0] DIST_MAX = {1'b0, {DIST_BITS{1'b1}}};

    logic                 any_cand;
    logic [DIST_BITS-1:0] best;

    // neighbor k at row r (0 is the row above), column c (0 is the left)
    always_comb
    begin
        logic [DIST_BITS:0] sum;
        logic               allow;
        logic               diag;
        int                 r;
        int                 c;
        any_cand = 1'b0;
        best     = '1;
        for (int k = 0; k < 9; k++)
        begin
            r     = k / 3;
            c     = k % 3;
            diag  = (r != 1) && (c != 1);
            allow = nb_fr[k] && (k != 4) &&
                    (!diag || (!nb_blk[3 + c] && !nb_blk[r * 3 + 1]));
            sum   = {1'b0, nb_dist[k*DIST_BITS +: DIST_BITS]} +
                    (DIST_BITS+1)'(diag ? STEP_DIAGONAL : STEP_STRAIGHT);
            if (sum > DIST_MAX)
            begin
                sum = DIST_MAX;
            end
            if (allow && (!any_cand || sum[DIST_BITS-1:0] < best))
            begin
                best = sum[DIST_BITS-1:0];
            end
            any_cand = any_cand | allow;
        end
    end

    assign grew     = !self_vld && !nb_blk[4] && in_map && any_cand;
    assign new_vld  = self_vld | grew;
    assign new_fr   = grew;
    assign new_dist = grew ? best : nb_dist[4*DIST_BITS +: DIST_BITS];

endmodule

/* src/grid_wavefront_distance_field.sv */
// channel  dir  handshake            payload
// s        in   s_tvalid/s_tready    s_tuser cmd, s_tdata x y blocked is_entry is_exit
// m        out  m_tvalid/m_tready    m_tdata ok status next_x next_y moved distance dist_valid
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// load cell and query read the addressed row and the rows above and below it, then hand off the result
// rebuild and clear take (rounds + 2) row memory sweeps, rounds being the wavefront depth;
// trial adds one sweep for the rollback, and so does set when no entry is reached
// each sweep pushes the map rows one at a time through the row of cells
// reset clears the per-row valid bits, so no clearing pass is needed
// a new item is taken while a result still waits in the output register
module grid_wavefront_distance_field #(
    parameter int MAX_WIDTH  = gwdf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gwdf_pkg::MAX_HEIGHT_DEF,
    parameter int DIST_BITS  = gwdf_pkg::DIST_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // cmd
    input  logic [15:0] s_tdata,   // x, y, blocked, is_entry, is_exit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // ok, status, next_x, next_y, moved, distance, dist_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    import gwdf_pkg::*;

    localparam int MW       = MAX_WIDTH;
    localparam int MH       = MAX_HEIGHT;
    localparam int DB       = DIST_BITS;
    localparam int XW       = $clog2(MW);
    localparam int YW       = $clog2(MH);
    localparam int OFF_BLK  = 0;
    localparam int OFF_ENT  = MW;
    localparam int OFF_EXT  = 2 * MW;
    localparam int OFF_VLD  = 3 * MW;
    localparam int OFF_FR   = 4 * MW;
    localparam int OFF_SBLK = 5 * MW;
    localparam int OFF_SVLD = 6 * MW;
    localparam int OFF_DIST = 7 * MW;
    localparam int OFF_SDST = 7 * MW + MW * DB;
    localparam int ROW_BITS = 7 * MW + 2 * MW * DB;
    localparam logic [ROW_BITS-1:0] PAD_WORD = {{(ROW_BITS-MW){1'b0}}, {MW{1'b1}}};

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [6:0]          w_reg, h_reg;
    logic [COORD_W-1:0]  cur_w, cur_h;
    logic [YW-1:0]       row_reg, row_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [5:0]          x_reg, x_next, y_reg, y_next;
    logic                blk_reg, blk_next, ent_reg, ent_next, ext_reg, ext_next;
    logic [ROW_BITS-1:0] prev_reg, prev_next, cur_reg, cur_next, nxt_reg, nxt_next;
    logic                any_reg, any_next, entry_reg, entry_next;
    logic                res_ok_reg, res_ok_next;
    logic [2:0]          res_status_reg, res_status_next;
    logic [5:0]          res_nx_reg, res_nx_next, res_ny_reg, res_ny_next;
    logic                res_moved_reg, res_moved_next;
    logic [15:0]         res_dist_reg, res_dist_next;
    logic                res_dvld_reg, res_dvld_next;
    logic                m_valid_reg, m_valid_next;
    logic [39:0]         m_data_reg, m_data_next;
    logic [MH-1:0]       row_ok_reg, row_ok_next;
    logic                rd_ok_reg;

    logic                ram_we;
    logic [YW-1:0]       ram_waddr, ram_raddr;
    logic [ROW_BITS-1:0] ram_wdata, ram_rdata, rdata;

    logic [ROW_BITS-1:0] below_word, sw_word, load_word;
    logic [ROW_BITS-1:0] win [3];
    logic [MW-1:0]       cell_vld, cell_fr, cell_grew;
    logic [MW*DB-1:0]    cell_dist;
    logic                row_in, row_grew, row_ent, last_row;
    logic                round_more, round_ent;

    logic [2:0]          in_cmd;
    logic [5:0]          in_x, in_y;
    logic                in_inside;
    logic [XW-1:0]       xi;
    logic                c_blk, c_ent, c_ext, c_vld;
    logic [DB-1:0]       c_dist;
    logic                protect, nochange;
    logic                out_free;

    logic                qblk [3][3];
    logic                qvld [3][3];
    logic [DB-1:0]       qdist [3][3];
    logic [5:0]          q_nx, q_ny;
    logic                q_moved;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign in_cmd    = s_tuser;
    assign in_x      = s_tdata[5:0];
    assign in_y      = s_tdata[11:6];
    assign in_inside = (COORD_W'(in_x) < cur_w) && (COORD_W'(in_y) < cur_h);
    assign out_free  = !m_valid_reg || m_tready;

    always_comb
    begin
        logic [COORD_W-1:0] wv, hv;
        wv = COORD_W'(w_reg);
        hv = COORD_W'(h_reg);
        if (wv < COORD_W'(MIN_DIM))
        begin
            cur_w = COORD_W'(MIN_DIM);
        end
        else if (wv > COORD_W'(MW))
        begin
            cur_w = COORD_W'(MW);
        end
        else
        begin
            cur_w = wv;
        end
        if (hv < COORD_W'(MIN_DIM))
        begin
            cur_h = COORD_W'(MIN_DIM);
        end
        else if (hv > COORD_W'(MH))
        begin
            cur_h = COORD_W'(MH);
        end
        else
        begin
            cur_h = hv;
        end
    end

    gwdf_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // rows never written read as the reset map
    assign rdata = rd_ok_reg ? ram_rdata : '0;

    // row of cells, one per column
    assign last_row   = (row_reg == YW'(MH - 1));
    assign below_word = last_row ? PAD_WORD : rdata;
    assign row_in     = COORD_W'(row_reg) < cur_h;
    assign win[0]     = prev_reg;
    assign win[1]     = cur_reg;
    assign win[2]     = below_word;

    for (genvar c = 0; c < MW; c++)
    begin : g_col
        logic [8:0]      nbb, nbf;
        logic [9*DB-1:0] nbd;
        for (genvar r = 0; r < 3; r++)
        begin : g_r
            for (genvar j = 0; j < 3; j++)
            begin : g_j
                if ((c + j - 1 < 0) || (c + j - 1 >= MW))
                begin : g_pad
                    assign nbb[r*3+j]          = 1'b1;
                    assign nbf[r*3+j]          = 1'b0;
                    assign nbd[(r*3+j)*DB +: DB] = '0;
                end
                else
                begin : g_in
                    assign nbb[r*3+j]          = win[r][OFF_BLK + c + j - 1];
                    assign nbf[r*3+j]          = win[r][OFF_FR + c + j - 1];
                    assign nbd[(r*3+j)*DB +: DB] = win[r][OFF_DIST + (c+j-1)*DB +: DB];
                end
            end
        end

        gwdf_cell #(
            .DIST_BITS (DB)
        ) u_cell (
            .nb_blk   (nbb),
            .nb_fr    (nbf),
            .nb_dist  (nbd),
            .self_vld (cur_reg[OFF_VLD + c]),
            .in_map   (row_in && (COORD_W'(c) < cur_w)),
            .new_vld  (cell_vld[c]),
            .new_fr   (cell_fr[c]),
            .new_dist (cell_dist[c*DB +: DB]),
            .grew     (cell_grew[c])
        );
    end

    // new row word for the sweep in progress
    always_comb
    begin
        logic inm, border, nb, seed, ent, ext;
        sw_word  = cur_reg;
        row_grew = |cell_grew;
        row_ent  = 1'b0;
        for (int c = 0; c < MW; c++)
        begin
            inm    = row_in && (COORD_W'(c) < cur_w);
            ent    = cur_reg[OFF_ENT + c];
            ext    = cur_reg[OFF_EXT + c];
            border = (c == 0) || (COORD_W'(c) == cur_w - COORD_W'(1)) ||
                     (row_reg == '0) || (COORD_W'(row_reg) == cur_h - COORD_W'(1));
            nb     = cur_reg[OFF_BLK + c];
            if (cmd_reg == CMD_CLEAR)
            begin
                nb = inm && border && !(ent || ext);
            end
            else if ((cmd_reg == CMD_SET || cmd_reg == CMD_TRIAL) &&
                     (COORD_W'(row_reg) == COORD_W'(y_reg)) &&
                     (COORD_W'(c) == COORD_W'(x_reg)))
            begin
                nb = (cmd_reg == CMD_SET) ? blk_reg : 1'b1;
            end
            seed = ext && !nb && inm;
            row_ent = row_ent | (ent && cell_vld[c] && inm);
            case (phase_reg)
                PH_INIT:
                begin
                    sw_word[OFF_BLK + c]            = nb;
                    sw_word[OFF_VLD + c]            = seed;
                    sw_word[OFF_FR + c]             = seed;
                    sw_word[OFF_DIST + c*DB +: DB]  = '0;
                    sw_word[OFF_SBLK + c]           = cur_reg[OFF_BLK + c];
                    sw_word[OFF_SVLD + c]           = cur_reg[OFF_VLD + c];
                    sw_word[OFF_SDST + c*DB +: DB]  = cur_reg[OFF_DIST + c*DB +: DB];
                end
                PH_ROUND:
                begin
                    sw_word[OFF_VLD + c]            = cell_vld[c];
                    sw_word[OFF_FR + c]             = cell_fr[c];
                    sw_word[OFF_DIST + c*DB +: DB]  = cell_dist[c*DB +: DB];
                end
                PH_RESTORE:
                begin
                    sw_word[OFF_BLK + c]            = cur_reg[OFF_SBLK + c];
                    sw_word[OFF_VLD + c]            = cur_reg[OFF_SVLD + c];
                    sw_word[OFF_DIST + c*DB +: DB]  = cur_reg[OFF_SDST + c*DB +: DB];
                end
                default:
                begin
                    sw_word[OFF_FR + c] = 1'b0;
                end
            endcase
        end
    end

    assign round_more = any_reg | row_grew;
    assign round_ent  = entry_reg | row_ent;

    // addressed cell
    assign xi       = XW'(x_reg);
    assign c_blk    = cur_reg[OFF_BLK + xi];
    assign c_ent    = cur_reg[OFF_ENT + xi];
    assign c_ext    = cur_reg[OFF_EXT + xi];
    assign c_vld    = cur_reg[OFF_VLD + xi];
    assign c_dist   = cur_reg[OFF_DIST + xi*DB +: DB];
    assign protect  = c_ent || c_ext;
    assign nochange = (cmd_reg == CMD_SET && c_blk == blk_reg) ||
                      (cmd_reg == CMD_TRIAL && c_blk);

    always_comb
    begin
        load_word = cur_reg;
        load_word[OFF_BLK + xi] = blk_reg;
        load_word[OFF_ENT + xi] = ent_reg;
        load_word[OFF_EXT + xi] = ext_reg;
    end

    // next step downhill, first lowest direction wins
    always_comb
    begin
        logic [COORD_W-1:0]  col;
        logic                rok, inm;
        logic [XW-1:0]       ci;
        logic [ROW_BITS-1:0] wd;
        logic [DB-1:0]       best;
        logic [DB:0]         sum;
        logic                sok;
        int                  r;
        int                  c;
        for (int rr = 0; rr < 3; rr++)
        begin
            for (int cc = 0; cc < 3; cc++)
            begin
                col = COORD_W'(x_reg) + COORD_W'(cc) - COORD_W'(1);
                if (rr == 0)
                begin
                    rok = (y_reg != '0);
                    wd  = prev_reg;
                end
                else if (rr == 1)
                begin
                    rok = 1'b1;
                    wd  = cur_reg;
                end
                else
                begin
                    rok = (COORD_W'(y_reg) + COORD_W'(1)) < cur_h;
                    wd  = nxt_reg;
                end
                inm = rok && (col < cur_w);
                ci  = XW'(col);
                qblk[rr][cc]  = !inm || wd[OFF_BLK + ci];
                qvld[rr][cc]  = inm && wd[OFF_VLD + ci];
                qdist[rr][cc] = wd[OFF_DIST + ci*DB +: DB];
            end
        end
        best    = qdist[1][1];
        q_nx    = x_reg;
        q_ny    = y_reg;
        for (int d = 0; d < NDIRS; d++)
        begin
            r   = DIR_DY[d] + 1;
            c   = DIR_DX[d] + 1;
            sok = !qblk[r][c] && (((d & 1) == 0) || (!qblk[1][c] && !qblk[r][1]));
            sum = {1'b0, qdist[r][c]} +
                  (DB+1)'(((d & 1) != 0) ? STEP_DIAGONAL : STEP_STRAIGHT);
            if (sok && qvld[r][c] && sum == {1'b0, qdist[1][1]} && qdist[r][c] < best)
            begin
                best = qdist[r][c];
                q_nx = 6'(int'(x_reg) + DIR_DX[d]);
                q_ny = 6'(int'(y_reg) + DIR_DY[d]);
            end
        end
        q_moved = (best != qdist[1][1]);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_cmd > CMD_CLEAR)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (in_cmd == CMD_REBUILD || in_cmd == CMD_CLEAR)
                    begin
                        state_next = ST_SW_PRE;
                    end
                    else if (!in_inside)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_FETCH0;
                    end
                end
            end
            ST_FETCH0:  state_next = ST_FETCH1;
            ST_FETCH1:  state_next = ST_FETCH2;
            ST_FETCH2:  state_next = ST_FETCH3;
            ST_FETCH3:  state_next = ST_OPER;
            ST_OPER:
            begin
                if ((cmd_reg == CMD_SET || cmd_reg == CMD_TRIAL) && !protect && !nochange)
                begin
                    state_next = ST_SW_PRE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SW_PRE:  state_next = ST_SW_LOAD;
            ST_SW_LOAD: state_next = ST_SW_RD;
            ST_SW_RD:   state_next = ST_SW_WR;
            ST_SW_WR:
            begin
                if (!last_row)
                begin
                    state_next = ST_SW_RD;
                end
                else
                begin
                    case (phase_reg)
                        PH_INIT:  state_next = ST_SW_PRE;
                        PH_ROUND:
                        begin
                            if (round_more)
                            begin
                                state_next = ST_SW_PRE;
                            end
                            else if (cmd_reg == CMD_REBUILD || cmd_reg == CMD_CLEAR ||
                                     (cmd_reg == CMD_SET && round_ent))
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SW_PRE;
                            end
                        end
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        phase_next      = phase_reg;
        row_next        = row_reg;
        cmd_next        = cmd_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        blk_next        = blk_reg;
        ent_next        = ent_reg;
        ext_next        = ext_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        any_next        = any_reg;
        entry_next      = entry_reg;
        res_ok_next     = res_ok_reg;
        res_status_next = res_status_reg;
        res_nx_next     = res_nx_reg;
        res_ny_next     = res_ny_reg;
        res_moved_next  = res_moved_reg;
        res_dist_next   = res_dist_reg;
        res_dvld_next   = res_dvld_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        row_ok_next     = row_ok_reg;
        ram_we          = 1'b0;
        ram_waddr       = row_reg;
        ram_wdata       = sw_word;
        ram_raddr       = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next        = in_cmd;
                    x_next          = in_x;
                    y_next          = in_y;
                    blk_next        = s_tdata[12];
                    ent_next        = s_tdata[13];
                    ext_next        = s_tdata[14];
                    phase_next      = PH_INIT;
                    res_ok_next     = 1'b0;
                    res_nx_next     = in_x;
                    res_ny_next     = in_y;
                    res_moved_next  = 1'b0;
                    res_dist_next   = '0;
                    res_dvld_next   = 1'b0;
                    if (in_cmd > CMD_CLEAR)
                    begin
                        res_status_next = STAT_NOCHANGE;
                    end
                    else if (in_cmd == CMD_REBUILD || in_cmd == CMD_CLEAR || in_inside)
                    begin
                        res_status_next = STAT_DONE;
                    end
                    else
                    begin
                        res_status_next = STAT_OUTSIDE;
                    end
                end
            end
            ST_FETCH0:
            begin
                ram_raddr = YW'(y_reg - 6'd1);
            end
            ST_FETCH1:
            begin
                prev_next = (y_reg != '0) ? rdata : PAD_WORD;
                ram_raddr = YW'(y_reg);
            end
            ST_FETCH2:
            begin
                cur_next  = rdata;
                ram_raddr = YW'(COORD_W'(y_reg) + COORD_W'(1));
            end
            ST_FETCH3:
            begin
                nxt_next = ((COORD_W'(y_reg) + COORD_W'(1)) < COORD_W'(MH)) ? rdata : PAD_WORD;
            end
            ST_OPER:
            begin
                case (cmd_reg)
                    CMD_LOAD:
                    begin
                        ram_we                  = 1'b1;
                        ram_waddr               = YW'(y_reg);
                        ram_wdata               = load_word;
                        row_ok_next[YW'(y_reg)] = 1'b1;
                        res_ok_next             = 1'b1;
                    end
                    CMD_SET, CMD_TRIAL:
                    begin
                        if (protect)
                        begin
                            res_status_next = STAT_PROTECT;
                        end
                        else if (nochange)
                        begin
                            res_status_next = STAT_NOCHANGE;
                        end
                    end
                    CMD_QUERY:
                    begin
                        res_dist_next = 16'(c_dist);
                        res_dvld_next = c_vld;
                        if (c_blk)
                        begin
                            res_status_next = STAT_NOCHANGE;
                        end
                        else if (!c_vld)
                        begin
                            res_status_next = STAT_NODIST;
                        end
                        else
                        begin
                            res_ok_next    = 1'b1;
                            res_nx_next    = q_nx;
                            res_ny_next    = q_ny;
                            res_moved_next = q_moved;
                        end
                    end
                    default:
                    begin
                        res_status_next = STAT_NOCHANGE;
                    end
                endcase
            end
            ST_SW_PRE:
            begin
                ram_raddr  = '0;
                any_next   = 1'b0;
                entry_next = 1'b0;
            end
            ST_SW_LOAD:
            begin
                cur_next  = rdata;
                prev_next = PAD_WORD;
                row_next  = '0;
            end
            ST_SW_RD:
            begin
                ram_raddr = YW'(COORD_W'(row_reg) + COORD_W'(1));
            end
            ST_SW_WR:
            begin
                ram_we               = 1'b1;
                row_ok_next[row_reg] = 1'b1;
                any_next             = round_more;
                entry_next           = round_ent;
                prev_next            = cur_reg;
                cur_next             = below_word;
                row_next             = YW'(COORD_W'(row_reg) + COORD_W'(1));
                if (last_row)
                begin
                    case (phase_reg)
                        PH_INIT:
                        begin
                            phase_next = PH_ROUND;
                        end
                        PH_ROUND:
                        begin
                            if (!round_more)
                            begin
                                res_ok_next     = round_ent;
                                res_status_next = round_ent ? STAT_DONE : STAT_UNREACH;
                                if (cmd_reg == CMD_TRIAL || (cmd_reg == CMD_SET && !round_ent))
                                begin
                                    phase_next = PH_RESTORE;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_INIT;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, res_dvld_reg, res_dist_reg, res_moved_reg,
                                    res_ny_reg, res_nx_reg, res_status_reg, res_ok_reg};
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_INIT;
            m_valid_reg <= 1'b0;
            row_ok_reg  <= '0;
            rd_ok_reg   <= 1'b0;
            w_reg       <= 7'd64;
            h_reg       <= 7'd64;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            row_ok_reg  <= row_ok_next;
            rd_ok_reg   <= row_ok_reg[ram_raddr];
            if (cfg_valid && cfg_index == REG_WIDTH)
            begin
                w_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_HEIGHT)
            begin
                h_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        cmd_reg        <= cmd_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        blk_reg        <= blk_next;
        ent_reg        <= ent_next;
        ext_reg        <= ext_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        nxt_reg        <= nxt_next;
        any_reg        <= any_next;
        entry_reg      <= entry_next;
        res_ok_reg     <= res_ok_next;
        res_status_reg <= res_status_next;
        res_nx_reg     <= res_nx_next;
        res_ny_reg     <= res_ny_next;
        res_moved_reg  <= res_moved_next;
        res_dist_reg   <= res_dist_next;
        res_dvld_reg   <= res_dvld_next;
        m_data_reg     <= m_data_next;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

import gwdf_pkg::*;

typedef struct {
    bit          ok;
    bit [2:0]    status;
    bit [5:0]    next_x;
    bit [5:0]    next_y;
    bit          moved;
    bit [15:0]   distance;
    bit          dist_valid;
} route_answer_t;

class field_scoreboard;
    localparam int NC = 4096;
    bit          blk [NC];
    bit          ent [NC];
    bit          ext [NC];
    int unsigned dmap [NC];
    bit          dval [NC];
    bit          sv_blk [NC];
    int unsigned sv_dist [NC];
    bit          sv_dval [NC];
    int          width_reg = 64;
    int          height_reg = 64;
    route_answer_t answers [$];
    int          errors = 0;
    int          checked = 0;
    int          cmd_seen [8];

    function int cur_w();
        return width_reg < MIN_DIM ? MIN_DIM : (width_reg > 64 ? 64 : width_reg);
    endfunction

    function int cur_h();
        return height_reg < MIN_DIM ? MIN_DIM : (height_reg > 64 ? 64 : height_reg);
    endfunction

    function void write_reg(bit idx, bit [6:0] val);
        if (idx == REG_WIDTH)
            width_reg = int'(val);
        else
            height_reg = int'(val);
    endfunction

    function bit road(int x, int y);
        return !blk[y * 64 + x];
    endfunction

    function bit step_ok(int x, int y, int d, int w, int h);
        int nx;
        int ny;
        int p;
        int q;
        nx = x + DIR_DX[d];
        ny = y + DIR_DY[d];
        if (nx < 0 || nx >= w || ny < 0 || ny >= h || !road(nx, ny))
            return 0;
        if (d % 2 == 0)
            return 1;
        p = (d + NDIRS - 1) % NDIRS;
        q = (d + 1) % NDIRS;
        return road(x + DIR_DX[p], y + DIR_DY[p]) && road(x + DIR_DX[q], y + DIR_DY[q]);
    endfunction

    function bit rebuild();
        int w;
        int h;
        int c;
        int cx;
        int cy;
        int ni;
        int unsigned t;
        int wave [$];
        int wave_next [$];
        bit closed [NC];
        bit front [NC];
        w = cur_w();
        h = cur_h();
        for (int i = 0; i < NC; i++)
        begin
            dmap[i] = 0;
            dval[i] = 0;
        end
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                if (ext[y * 64 + x] && !blk[y * 64 + x])
                begin
                    dval[y * 64 + x] = 1;
                    front[y * 64 + x] = 1;
                    wave = {wave, y * 64 + x};
                end
        while (wave.size() > 0)
        begin
            foreach (wave[k])
                closed[wave[k]] = 1;
            wave_next = {};
            foreach (wave[k])
            begin
                c = wave[k];
                cx = c % 64;
                cy = c / 64;
                for (int d = 0; d < NDIRS; d++)
                begin
                    if (!step_ok(cx, cy, d, w, h))
                        continue;
                    ni = (cy + DIR_DY[d]) * 64 + cx + DIR_DX[d];
                    if (closed[ni])
                        continue;
                    t = dmap[c] + ((d % 2) ? STEP_DIAGONAL : STEP_STRAIGHT);
                    if (t > 65535)
                        t = 65535;
                    if (!dval[ni] || dmap[ni] > t)
                    begin
                        dmap[ni] = t;
                        dval[ni] = 1;
                        if (!front[ni])
                        begin
                            front[ni] = 1;
                            wave_next = {wave_next, ni};
                        end
                    end
                end
            end
            wave = wave_next;
        end
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                if (ent[y * 64 + x] && dval[y * 64 + x])
                    return 1;
        return 0;
    endfunction

    function bit clear_map();
        int w;
        int h;
        w = cur_w();
        h = cur_h();
        for (int i = 0; i < NC; i++)
            blk[i] = 0;
        for (int x = 0; x < w; x++)
        begin
            blk[x] = 1;
            blk[(h - 1) * 64 + x] = 1;
        end
        for (int y = 0; y < h; y++)
        begin
            blk[y * 64] = 1;
            blk[y * 64 + w - 1] = 1;
        end
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                if (ent[y * 64 + x] || ext[y * 64 + x])
                    blk[y * 64 + x] = 0;
        return rebuild();
    endfunction

    function void note_item(bit [2:0] cmd, int x, int y, bit b, bit e, bit xt);
        route_answer_t a;
        int i;
        int w;
        int h;
        bit r;
        int unsigned best;
        a = '{default: 0};
        a.next_x = 6'(x);
        a.next_y = 6'(y);
        i = y * 64 + x;
        w = cur_w();
        h = cur_h();
        cmd_seen[cmd]++;
        if (cmd > CMD_CLEAR)
            a.status = STAT_NOCHANGE;
        else if (cmd == CMD_REBUILD || cmd == CMD_CLEAR)
        begin
            a.ok = (cmd == CMD_REBUILD) ? rebuild() : clear_map();
            a.status = a.ok ? STAT_DONE : STAT_UNREACH;
        end
        else if (x >= w || y >= h)
            a.status = STAT_OUTSIDE;
        else if (cmd == CMD_LOAD)
        begin
            blk[i] = b;
            ent[i] = e;
            ext[i] = xt;
            a.ok = 1;
        end
        else if (cmd == CMD_SET || cmd == CMD_TRIAL)
        begin
            if (ent[i] || ext[i])
                a.status = STAT_PROTECT;
            else if ((cmd == CMD_SET && blk[i] == b) || (cmd == CMD_TRIAL && blk[i]))
                a.status = STAT_NOCHANGE;
            else
            begin
                sv_blk = blk;
                sv_dist = dmap;
                sv_dval = dval;
                blk[i] = (cmd == CMD_SET) ? b : 1'b1;
                r = rebuild();
                if (!r || cmd == CMD_TRIAL)
                begin
                    blk = sv_blk;
                    dmap = sv_dist;
                    dval = sv_dval;
                end
                a.ok = r;
                a.status = r ? STAT_DONE : STAT_UNREACH;
            end
        end
        else
        begin
            a.distance = 16'(dmap[i]);
            a.dist_valid = dval[i];
            if (blk[i])
                a.status = STAT_NOCHANGE;
            else if (!dval[i])
                a.status = STAT_NODIST;
            else
            begin
                best = dmap[i];
                for (int d = 0; d < NDIRS; d++)
                begin
                    int ni;
                    int unsigned off;
                    off = (d % 2) ? STEP_DIAGONAL : STEP_STRAIGHT;
                    if (!step_ok(x, y, d, w, h))
                        continue;
                    ni = (y + DIR_DY[d]) * 64 + x + DIR_DX[d];
                    if (!dval[ni])
                        continue;
                    if (dmap[ni] + off == dmap[i] && dmap[ni] < best)
                    begin
                        best = dmap[ni];
                        a.next_x = 6'(x + DIR_DX[d]);
                        a.next_y = 6'(y + DIR_DY[d]);
                    end
                end
                a.moved = best != dmap[i];
                a.ok = 1;
            end
        end
        answers = {answers, a};
    endfunction

    function void cmp(string name, int unsigned e, int unsigned g);
        if (e != g)
        begin
            $error("%s: expected %0d, got %0d", name, e, g);
            errors++;
        end
    endfunction

    function void check_result(logic [39:0] d);
        route_answer_t a;
        if (answers.size() == 0)
        begin
            $error("result 0x%h with no item outstanding", d);
            errors++;
            return;
        end
        a = answers.pop_front();
        checked++;
        cmp("ok", a.ok, d[0]);
        cmp("status", a.status, d[3:1]);
        cmp("next_x", a.next_x, d[9:4]);
        cmp("next_y", a.next_y, d[15:10]);
        cmp("moved", a.moved, d[16]);
        cmp("distance", a.distance, d[32:17]);
        cmp("dist_valid", a.dist_valid, d[33]);
    endfunction
endclass

module tb;
    localparam logic [2:0] CMD_BAD_LO = 3'd6;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;   // cmd
    logic [15:0] s_tdata;   // x, y, blocked, is_entry, is_exit
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // ok, status, next_x, next_y, moved, distance, dist_valid
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [6:0]  cfg_data;

    field_scoreboard sb;
    bit quiet = 0;
    int stall_left = 0;
    int random_items = 0;

    grid_wavefront_distance_field u_dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("Mismatches found");
        $finish;
    end

    // monitor: note accepted items before checking results
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
        if (rst_n && s_tvalid && s_tready)
            sb.note_item(s_tuser, s_tdata[5:0], s_tdata[11:6], s_tdata[12], s_tdata[13],
                         s_tdata[14]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if (quiet)
            m_tready <= 1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 12) - 1;
            m_tready <= 0;
        end
        else
            m_tready <= 1;
    end

    task automatic send_item(logic [2:0] cmd, int x, int y, bit b = 0, bit e = 0,
                             bit xt = 0);
        int gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, xt, e, b, y[5:0], x[5:0]};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (sb.answers.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(bit idx, bit [6:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic random_phase(int n_ops);
        int w;
        int h;
        int sel;
        int x;
        int y;
        w = sb.cur_w();
        h = sb.cur_h();
        for (int k = 0; k < $urandom_range(1, 2); k++)
            send_item(CMD_LOAD, $urandom_range(1, w - 2), $urandom_range(1, h - 2), 0, 0, 1);
        for (int k = 0; k < $urandom_range(1, 2); k++)
            send_item(CMD_LOAD, $urandom_range(1, w - 2), $urandom_range(1, h - 2), 0, 1, 0);
        send_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
        random_items += 5;
        for (int k = 0; k < n_ops; k++)
        begin
            sel = $urandom_range(0, 19);
            x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, w - 1);
            y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, h - 1);
            if (sel < 6)
                send_item(CMD_SET, x, y, 1'($urandom_range(0, 1)));
            else if (sel < 9)
                send_item(CMD_TRIAL, x, y);
            else if (sel < 15)
                send_item(CMD_QUERY, x, y);
            else if (sel < 17)
                send_item(CMD_LOAD, x, y, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                          $urandom_range(0, 3) == 0);
            else if (sel < 19)
                send_item(CMD_REBUILD, x, y);
            else
                send_item($urandom_range(0, 1) ? CMD_BAD_HI : CMD_BAD_LO, x, y,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            random_items++;
        end
        drain();
    endtask

    initial
    begin
        sb = new;
        rst_n = 0;
        s_tvalid = 0;
        s_tuser = 0;
        s_tdata = 0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: full-size map
        send_item(CMD_QUERY, 10, 10);
        send_item(CMD_BAD_LO, 63, 63, 1, 1, 1);
        send_item(CMD_BAD_HI, 0, 0);
        send_item(CMD_LOAD, 63, 63, 1, 1, 1);
        send_item(CMD_LOAD, 63, 63, 0, 1, 0);
        send_item(CMD_LOAD, 1, 1, 0, 0, 1);
        send_item(CMD_CLEAR, 0, 0);
        send_item(CMD_LOAD, 63, 62, 0, 0, 0);
        send_item(CMD_REBUILD, 0, 0);
        send_item(CMD_QUERY, 63, 63);
        send_item(CMD_QUERY, 0, 0);
        send_item(CMD_SET, 5, 5, 1);
        send_item(CMD_SET, 5, 5, 1);
        send_item(CMD_SET, 63, 63, 1);
        send_item(CMD_TRIAL, 6, 6);
        send_item(CMD_TRIAL, 5, 5);
        send_item(CMD_QUERY, 6, 5);
        drain();

        // directed: clamped registers, then a cut-off entry
        write_cfg(REG_WIDTH, 7'd0);
        write_cfg(REG_HEIGHT, 7'd127);
        send_item(CMD_QUERY, 5, 0);
        send_item(CMD_TRIAL, 2, 63);
        drain();
        write_cfg(REG_WIDTH, 7'd5);
        write_cfg(REG_HEIGHT, 7'd5);
        send_item(CMD_LOAD, 1, 1, 0, 1, 0);
        send_item(CMD_LOAD, 3, 3, 0, 0, 1);
        send_item(CMD_CLEAR, 0, 0);
        send_item(CMD_SET, 2, 1, 1);
        send_item(CMD_SET, 1, 2, 1);
        send_item(CMD_SET, 2, 2, 1);
        send_item(CMD_QUERY, 3, 2);
        drain();

        while (random_items < 64)
        begin
            case ($urandom_range(0, 7))
                0: begin
                    write_cfg(REG_WIDTH, 7'd64);
                    write_cfg(REG_HEIGHT, 7'($urandom_range(3, 12)));
                end
                1: begin
                    write_cfg(REG_WIDTH, 7'($urandom_range(0, 2)));
                    write_cfg(REG_HEIGHT, 7'($urandom_range(65, 127)));
                end
                default: begin
                    write_cfg(REG_WIDTH, 7'($urandom_range(3, 12)));
                    write_cfg(REG_HEIGHT, 7'($urandom_range(3, 12)));
                end
            endcase
            if (random_items > 44)
                quiet = 1;
            random_phase($urandom_range(8, 16));
        end
        quiet = 1;
        write_cfg(REG_WIDTH, 7'd64);
        write_cfg(REG_HEIGHT, 7'd64);
        random_phase(6);

        $display("covered %0d results: load %0d, rebuild %0d, set %0d, trial %0d",
                 sb.checked, sb.cmd_seen[0], sb.cmd_seen[1], sb.cmd_seen[2], sb.cmd_seen[3]);
        $display("query %0d, clear %0d, unknown %0d, over several map sizes",
                 sb.cmd_seen[4], sb.cmd_seen[5], sb.cmd_seen[6] + sb.cmd_seen[7]);
        if (sb.errors == 0 && sb.answers.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* sim.f */
src/gwdf_pkg.sv
src/gwdf_ram.sv
src/gwdf_cell.sv
src/grid_wavefront_distance_field.sv
tb/tb.sv
